// ===== design/packet_header_and_url_inspector_unit_defines.svh =====
// Assertion macros shared by the checker of the frame inspector.
// No dependencies; included by the checker file.
`ifndef PACKET_HEADER_AND_URL_INSPECTOR_UNIT_DEFINES_SVH
`define PACKET_HEADER_AND_URL_INSPECTOR_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PHUI_ASSERT_NOW(lbl, ck, rn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define PHUI_ASSERT_NEXT(lbl, ck, rn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) else $error(msg);

`endif

// ===== design/phui_pkg.sv =====
// Package of the frame inspector: types, layout constants and match strings.
// No dependencies; used by every design file but phui_if and the defines header.
package phui_pkg;

  localparam int POSITION_BITS_DEF = 16;
  localparam int COUNTER_BITS_DEF  = 32;
  localparam int CFG_ADDR_W        = 2;
  localparam int CFG_DATA_W        = 32;

  localparam logic [15:0] WATCH_PORT_RESET = 16'd80;
  localparam logic [15:0] ETYPE_IPV4       = 16'h0800;
  localparam logic [15:0] ETYPE_ARP        = 16'h0806;
  localparam logic [7:0]  PROTO_TCP        = 8'h06;

  localparam int POS_TYPE_HI   = 12;
  localparam int POS_TYPE_LO   = 13;
  localparam int POS_IHL       = 14;
  localparam int POS_PROTO     = 23;
  localparam int POS_SRC_FIRST = 26;
  localparam int POS_SRC_LAST  = 29;
  localparam int POS_DST_FIRST = 30;
  localparam int POS_DST_LAST  = 33;
  localparam int ETH_HDR_LEN   = 14;
  localparam int MIN_ARP_LEN   = 14;
  localparam int MIN_IPV4_LEN  = 34;
  localparam int TCP_PORT_HI   = 2;
  localparam int TCP_PORT_LO   = 3;
  localparam int TCP_OFF_BYTE  = 12;
  localparam int TCP_FLAG_BYTE = 13;
  localparam int TCP_MIN_LEN   = 20;
  localparam int HOST_A_LEN    = 16;
  localparam int HOST_B_LEN    = 13;

  localparam logic [3:0] MIN_HDR_WORDS = 4'd5;

  // Host strings, first byte on the wire in the most significant position.
  localparam logic [127:0] HOST_A = 128'h7777772e676f6f676c652e636f2e756b;
  localparam logic [103:0] HOST_B = 104'h7777772e6262632e636f2e756b;

  localparam logic [1:0] KIND_OTHER    = 2'd0;
  localparam logic [1:0] KIND_TCP      = 2'd1;
  localparam logic [1:0] KIND_ARP      = 2'd2;
  localparam logic [1:0] KIND_IPV4_OTH = 2'd3;

  localparam logic [1:0] HIT_NONE = 2'd0;
  localparam logic [1:0] HIT_A    = 2'd1;
  localparam logic [1:0] HIT_B    = 2'd2;

  typedef struct packed {
    logic [7:0] frame_byte;
    logic       end_of_frame;
  } item_t;

  typedef struct packed {
    logic [1:0]  packet_kind;
    logic        syn_seen;
    logic [1:0]  blacklist_hit;
    logic [31:0] source_address;
    logic [31:0] dest_address;
    logic [31:0] syn_total;
    logic [31:0] arp_total;
    logic [31:0] blacklist_total;
  } result_t;

endpackage

// ===== design/phui_if.sv =====
// Channel interfaces of the frame inspector: byte input and result output.
// No dependencies.
interface phui_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] frame_byte;
  logic       end_of_frame;

  modport source (output valid, output frame_byte, output end_of_frame, input ready);
  modport sink (input valid, input frame_byte, input end_of_frame, output ready);
endinterface

interface phui_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  packet_kind;
  logic        syn_seen;
  logic [1:0]  blacklist_hit;
  logic [31:0] source_address;
  logic [31:0] dest_address;
  logic [31:0] syn_total;
  logic [31:0] arp_total;
  logic [31:0] blacklist_total;

  modport source (output valid, output packet_kind, output syn_seen, output blacklist_hit,
                  output source_address, output dest_address, output syn_total,
                  output arp_total, output blacklist_total, input ready);
  modport sink (input valid, input packet_kind, input syn_seen, input blacklist_hit,
                input source_address, input dest_address, input syn_total,
                input arp_total, input blacklist_total, output ready);
endinterface

// ===== design/phui_cfg_regs.sv =====
// APB-style configuration register holding the watched TCP port.
// Depends on phui_pkg.
module phui_cfg_regs (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [phui_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [phui_pkg::CFG_DATA_W-1:0] prdata,
  output logic [15:0]                     watch_port
);

  logic [15:0] watch_port_r;
  logic [15:0] watch_port_nxt;

  always_comb begin
    watch_port_nxt = watch_port_r;
    if (psel && penable && pwrite) begin
      watch_port_nxt = pwdata[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      watch_port_r <= phui_pkg::WATCH_PORT_RESET;
    end else begin
      watch_port_r <= watch_port_nxt;
    end
  end

  assign watch_port = watch_port_r;
  assign prdata     = {{(phui_pkg::CFG_DATA_W - 16){1'b0}}, watch_port_r};

endmodule

// ===== design/phui_in_stage.sv =====
// Input register of the frame inspector; holds one byte until the parser takes it.
// Depends on phui_pkg and phui_if.
module phui_in_stage (
  input  logic            clk,
  input  logic            rst_n,
  phui_in_if.sink         in_chan,
  input  logic            advance,
  output logic            item_valid,
  output phui_pkg::item_t item
);

  logic            valid_r;
  logic            valid_nxt;
  phui_pkg::item_t item_r;
  logic            take;

  assign in_chan.ready = !valid_r || advance;
  assign take          = in_chan.valid && in_chan.ready;

  always_comb begin
    valid_nxt = valid_r;
    if (take) begin
      valid_nxt = 1'b1;
    end else if (advance) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      item_r <= '{frame_byte: in_chan.frame_byte, end_of_frame: in_chan.end_of_frame};
    end
  end

  assign item_valid = valid_r;
  assign item       = item_r;

endmodule

// ===== design/phui_frame_parser.sv =====
// Header field capture, host string matching, frame classification and totals.
// Depends on phui_pkg; feeds the result register in phui_out_stage.
module phui_frame_parser #(
  parameter int POSITION_BITS = phui_pkg::POSITION_BITS_DEF,
  parameter int COUNTER_BITS  = phui_pkg::COUNTER_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              advance,
  input  phui_pkg::item_t   item,
  input  logic [15:0]       watch_port,
  output phui_pkg::result_t result,
  output logic              result_load
);

  localparam int LW = POSITION_BITS + 1;
  localparam int EXT_W = (COUNTER_BITS > 32) ? COUNTER_BITS : 32;
  localparam logic [POSITION_BITS-1:0] POS_MAX = '1;
  localparam logic [COUNTER_BITS-1:0]  CNT_MAX = '1;

  logic [POSITION_BITS-1:0] pos_r, pos_nxt;
  logic [15:0]              etype_r, etype_nxt;
  logic [3:0]               ihl_r, ihl_nxt;
  logic [7:0]               proto_r, proto_nxt;
  logic [31:0]              src_r, src_nxt;
  logic [31:0]              dst_r, dst_nxt;
  logic [15:0]              port_r, port_nxt;
  logic [3:0]               thw_r, thw_nxt;
  logic                     syn_r, syn_nxt;
  logic [1:0]               hits_r, hits_nxt;
  logic [COUNTER_BITS-1:0]  syn_cnt_r, syn_cnt_nxt;
  logic [COUNTER_BITS-1:0]  arp_cnt_r, arp_cnt_nxt;
  logic [COUNTER_BITS-1:0]  hit_cnt_r, hit_cnt_nxt;
  logic [127:0]             win_r, win_nxt;

  logic [7:0]               b;
  logic [3:0]               ihl_eff, off_eff;
  logic [7:0]               tcp_start, pay_start;
  logic [POSITION_BITS-1:0] ts_p;
  logic [LW-1:0]            len;
  logic                     is_tcp;
  logic                     hit_a, hit_b;
  logic [1:0]               kind;
  logic [1:0]               hit_code;
  logic [EXT_W-1:0]         syn_ext, arp_ext, hit_ext;

  assign b       = item.frame_byte;
  assign win_nxt = {win_r[119:0], b};
  assign len     = {1'b0, pos_r} + LW'(1);

  always_comb begin
    etype_nxt = etype_r;
    ihl_nxt   = ihl_r;
    proto_nxt = proto_r;
    src_nxt   = src_r;
    dst_nxt   = dst_r;
    if (pos_r == POSITION_BITS'(phui_pkg::POS_TYPE_HI)) etype_nxt = {b, etype_r[7:0]};
    if (pos_r == POSITION_BITS'(phui_pkg::POS_TYPE_LO)) etype_nxt = {etype_r[15:8], b};
    if (pos_r == POSITION_BITS'(phui_pkg::POS_IHL)) ihl_nxt = b[3:0];
    if (pos_r == POSITION_BITS'(phui_pkg::POS_PROTO)) proto_nxt = b;
    if (pos_r >= POSITION_BITS'(phui_pkg::POS_SRC_FIRST) &&
        pos_r <= POSITION_BITS'(phui_pkg::POS_SRC_LAST)) begin
      src_nxt = {src_r[23:0], b};
    end
    if (pos_r >= POSITION_BITS'(phui_pkg::POS_DST_FIRST) &&
        pos_r <= POSITION_BITS'(phui_pkg::POS_DST_LAST)) begin
      dst_nxt = {dst_r[23:0], b};
    end
  end

  always_comb begin
    ihl_eff   = (ihl_nxt < phui_pkg::MIN_HDR_WORDS) ? phui_pkg::MIN_HDR_WORDS : ihl_nxt;
    tcp_start = 8'(phui_pkg::ETH_HDR_LEN) + {2'b00, ihl_eff, 2'b00};
    ts_p      = POSITION_BITS'(tcp_start);
    port_nxt  = port_r;
    thw_nxt   = thw_r;
    syn_nxt   = syn_r;
    if (pos_r == ts_p + POSITION_BITS'(phui_pkg::TCP_PORT_HI)) port_nxt = {b, port_r[7:0]};
    if (pos_r == ts_p + POSITION_BITS'(phui_pkg::TCP_PORT_LO)) port_nxt = {port_r[15:8], b};
    if (pos_r == ts_p + POSITION_BITS'(phui_pkg::TCP_OFF_BYTE)) thw_nxt = b[7:4];
    if (pos_r == ts_p + POSITION_BITS'(phui_pkg::TCP_FLAG_BYTE)) syn_nxt = b[1];
    off_eff   = (thw_nxt < phui_pkg::MIN_HDR_WORDS) ? phui_pkg::MIN_HDR_WORDS : thw_nxt;
    pay_start = tcp_start + {2'b00, off_eff, 2'b00};
  end

  always_comb begin
    is_tcp   = (etype_nxt == phui_pkg::ETYPE_IPV4) && (proto_nxt == phui_pkg::PROTO_TCP);
    hit_a    = is_tcp && (len >= LW'(pay_start) + LW'(phui_pkg::HOST_A_LEN)) &&
               (win_nxt == phui_pkg::HOST_A);
    hit_b    = is_tcp && (len >= LW'(pay_start) + LW'(phui_pkg::HOST_B_LEN)) &&
               (win_nxt[103:0] == phui_pkg::HOST_B);
    hits_nxt = hits_r | {hit_b, hit_a};
  end

  always_comb begin
    kind = phui_pkg::KIND_OTHER;
    if (etype_nxt == phui_pkg::ETYPE_ARP && len >= LW'(phui_pkg::MIN_ARP_LEN)) begin
      kind = phui_pkg::KIND_ARP;
    end else if (etype_nxt == phui_pkg::ETYPE_IPV4 && len >= LW'(phui_pkg::MIN_IPV4_LEN)) begin
      if (proto_nxt != phui_pkg::PROTO_TCP) begin
        kind = phui_pkg::KIND_IPV4_OTH;
      end else if (len >= LW'(tcp_start) + LW'(phui_pkg::TCP_MIN_LEN)) begin
        kind = phui_pkg::KIND_TCP;
      end
    end

    hit_code = phui_pkg::HIT_NONE;
    if (kind == phui_pkg::KIND_TCP && port_nxt == watch_port) begin
      if (hits_nxt[0]) begin
        hit_code = phui_pkg::HIT_A;
      end else if (hits_nxt[1]) begin
        hit_code = phui_pkg::HIT_B;
      end
    end

    syn_cnt_nxt = syn_cnt_r;
    arp_cnt_nxt = arp_cnt_r;
    hit_cnt_nxt = hit_cnt_r;
    if (item.end_of_frame) begin
      if (kind == phui_pkg::KIND_TCP && syn_nxt && syn_cnt_r != CNT_MAX) begin
        syn_cnt_nxt = syn_cnt_r + COUNTER_BITS'(1);
      end
      if (hit_code != phui_pkg::HIT_NONE && hit_cnt_r != CNT_MAX) begin
        hit_cnt_nxt = hit_cnt_r + COUNTER_BITS'(1);
      end
      if (kind == phui_pkg::KIND_ARP && arp_cnt_r != CNT_MAX) begin
        arp_cnt_nxt = arp_cnt_r + COUNTER_BITS'(1);
      end
    end

    pos_nxt = (pos_r < POS_MAX) ? pos_r + POSITION_BITS'(1) : pos_r;
  end

  assign syn_ext = EXT_W'(syn_cnt_nxt);
  assign arp_ext = EXT_W'(arp_cnt_nxt);
  assign hit_ext = EXT_W'(hit_cnt_nxt);

  always_comb begin
    result.packet_kind     = kind;
    result.syn_seen        = (kind == phui_pkg::KIND_TCP) ? syn_nxt : 1'b0;
    result.blacklist_hit   = hit_code;
    result.source_address  = (kind == phui_pkg::KIND_TCP || kind == phui_pkg::KIND_IPV4_OTH) ?
                             src_nxt : 32'd0;
    result.dest_address    = (kind == phui_pkg::KIND_TCP || kind == phui_pkg::KIND_IPV4_OTH) ?
                             dst_nxt : 32'd0;
    result.syn_total       = syn_ext[31:0];
    result.arp_total       = arp_ext[31:0];
    result.blacklist_total = hit_ext[31:0];
  end

  assign result_load = advance && item.end_of_frame;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r     <= '0;
      etype_r   <= '0;
      ihl_r     <= '0;
      proto_r   <= '0;
      src_r     <= '0;
      dst_r     <= '0;
      port_r    <= '0;
      thw_r     <= '0;
      syn_r     <= 1'b0;
      hits_r    <= '0;
      syn_cnt_r <= '0;
      arp_cnt_r <= '0;
      hit_cnt_r <= '0;
    end else if (advance) begin
      syn_cnt_r <= syn_cnt_nxt;
      arp_cnt_r <= arp_cnt_nxt;
      hit_cnt_r <= hit_cnt_nxt;
      if (item.end_of_frame) begin
        pos_r   <= '0;
        etype_r <= '0;
        ihl_r   <= '0;
        proto_r <= '0;
        src_r   <= '0;
        dst_r   <= '0;
        port_r  <= '0;
        thw_r   <= '0;
        syn_r   <= 1'b0;
        hits_r  <= '0;
      end else begin
        pos_r   <= pos_nxt;
        etype_r <= etype_nxt;
        ihl_r   <= ihl_nxt;
        proto_r <= proto_nxt;
        src_r   <= src_nxt;
        dst_r   <= dst_nxt;
        port_r  <= port_nxt;
        thw_r   <= thw_nxt;
        syn_r   <= syn_nxt;
        hits_r  <= hits_nxt;
      end
    end
  end

  // The window needs no clearing: a match is only taken once the whole
  // string lies inside the payload of the current frame.
  always_ff @(posedge clk) begin
    if (advance) begin
      win_r <= win_nxt;
    end
  end

endmodule

// ===== design/phui_out_stage.sv =====
// Result register of the frame inspector, driving the result channel.
// Depends on phui_pkg and phui_if.
module phui_out_stage (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              load,
  input  phui_pkg::result_t result,
  output logic              free,
  phui_out_if.source        out_chan
);

  logic              valid_r;
  logic              valid_nxt;
  phui_pkg::result_t result_r;

  assign free = !valid_r || out_chan.ready;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (out_chan.ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      result_r <= result;
    end
  end

  assign out_chan.valid           = valid_r;
  assign out_chan.packet_kind     = result_r.packet_kind;
  assign out_chan.syn_seen        = result_r.syn_seen;
  assign out_chan.blacklist_hit   = result_r.blacklist_hit;
  assign out_chan.source_address  = result_r.source_address;
  assign out_chan.dest_address    = result_r.dest_address;
  assign out_chan.syn_total       = result_r.syn_total;
  assign out_chan.arp_total       = result_r.arp_total;
  assign out_chan.blacklist_total = result_r.blacklist_total;

endmodule

// ===== design/packet_header_and_url_inspector_unit.sv =====
// Top level of the Ethernet/IPv4/TCP frame inspector.
// Depends on phui_pkg, phui_if, phui_cfg_regs, phui_in_stage, phui_frame_parser
// and phui_out_stage.
//
// Frame bytes enter on in_chan, one byte per transaction, with end_of_frame on
// the last byte. Each transaction is registered, then parsed by combinational
// logic that updates the header fields, the match window and the totals.
// A frame streams at line rate, one byte per cycle, unless a final byte waits.
// The last byte of a frame passes the input register, and its result is loaded
// into the result register, which drives one transaction on out_chan. Other
// bytes produce nothing. When out_chan stalls, bytes that end no frame keep
// flowing; a final byte waits in the input register until the result register
// frees, and in_chan ready drops behind it. The watched TCP port is written
// through the APB port whatever paddr holds; reads at address 0 return it.
// The user is to write it only while the block is idle; the block does not
// enforce this. pready is always high. Synchronous reset empties both
// registers, clears the per-frame state and the totals, and sets the watched
// port to 80. There is no clearing pass.
module packet_header_and_url_inspector_unit #(
  parameter int POSITION_BITS = phui_pkg::POSITION_BITS_DEF,
  parameter int COUNTER_BITS  = phui_pkg::COUNTER_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  phui_in_if.sink                         in_chan,
  phui_out_if.source                      out_chan,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [phui_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [phui_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [phui_pkg::CFG_DATA_W-1:0] prdata,
  output logic                            pready
);

  logic              item_valid;
  phui_pkg::item_t   item;
  logic              advance;
  logic              out_free;
  logic              result_load;
  phui_pkg::result_t result;
  logic [15:0]       watch_port;
  logic [phui_pkg::CFG_DATA_W-1:0] reg_rdata;

  assign pready  = 1'b1;
  assign prdata  = (paddr == '0) ? reg_rdata : '0;
  assign advance = item_valid && (!item.end_of_frame || out_free);

  phui_cfg_regs u_cfg (
    .clk        (clk),
    .rst_n      (rst_n),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .pwdata     (pwdata),
    .prdata     (reg_rdata),
    .watch_port (watch_port)
  );

  phui_in_stage u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_chan    (in_chan),
    .advance    (advance),
    .item_valid (item_valid),
    .item       (item)
  );

  phui_frame_parser #(
    .POSITION_BITS (POSITION_BITS),
    .COUNTER_BITS  (COUNTER_BITS)
  ) u_parser (
    .clk         (clk),
    .rst_n       (rst_n),
    .advance     (advance),
    .item        (item),
    .watch_port  (watch_port),
    .result      (result),
    .result_load (result_load)
  );

  phui_out_stage u_out (
    .clk      (clk),
    .rst_n    (rst_n),
    .load     (result_load),
    .result   (result),
    .free     (out_free),
    .out_chan (out_chan)
  );

endmodule

// ===== design/phui_checker.sv =====
// Port-level checker of the frame inspector and its bind to the top level.
// Depends on phui_pkg and packet_header_and_url_inspector_unit_defines.svh.
`include "packet_header_and_url_inspector_unit_defines.svh"

module phui_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        in_eof,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  out_kind,
  input logic        out_syn,
  input logic [1:0]  out_hit,
  input logic [31:0] out_src,
  input logic [31:0] out_syn_total
);

  `PHUI_ASSERT_NOW(a_reset_empty, clk, rst_n, !$past(rst_n), !out_valid && in_ready, "registers not empty after reset")

  `PHUI_ASSERT_NOW(a_result_from_last_byte, clk, rst_n, $rose(out_valid), $past(in_valid && in_ready && in_eof, 2), "result without an accepted final byte")

  `PHUI_ASSERT_NOW(a_tcp_only_flags, clk, rst_n, out_valid && (out_syn || out_hit != phui_pkg::HIT_NONE), out_kind == phui_pkg::KIND_TCP, "SYN or host hit reported for a non-TCP frame")

  `PHUI_ASSERT_NEXT(a_hold_on_stall, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_kind) && $stable(out_hit) && $stable(out_src) && $stable(out_syn_total), "result changed while stalled")

endmodule

bind packet_header_and_url_inspector_unit phui_checker u_phui_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_chan.valid),
  .in_ready      (in_chan.ready),
  .in_eof        (in_chan.end_of_frame),
  .out_valid     (out_chan.valid),
  .out_ready     (out_chan.ready),
  .out_kind      (out_chan.packet_kind),
  .out_syn       (out_chan.syn_seen),
  .out_hit       (out_chan.blacklist_hit),
  .out_src       (out_chan.source_address),
  .out_syn_total (out_chan.syn_total)
);

// ===== dv/frame_check_pkg.sv =====
// Scoreboard of the frame inspector testbench: predicts one verdict per frame
// from the accepted byte stream and checks the results in order.
// Depends on phui_pkg for the result type and the kind and hit codes.
package frame_check_pkg;
  import phui_pkg::*;

  localparam logic [15:0] DEFAULT_WATCH_PORT = 16'd80;
  localparam logic [15:0] ETH_TYPE_IPV4      = 16'h0800;
  localparam logic [15:0] ETH_TYPE_ARP       = 16'h0806;
  localparam logic [7:0]  IP_PROTO_TCP       = 8'h06;
  localparam logic [7:0]  IP_PROTO_UDP       = 8'h11;
  localparam int unsigned POS_LIMIT          = (1 << POSITION_BITS_DEF) - 1;
  localparam int          MAX_PRINTED        = 40;

  // The two watched host names in ASCII, first character in the top byte of each name's own length.
  localparam logic [127:0] HOST_LONG_BYTES  = 128'h7777772e676f6f676c652e636f2e756b;
  localparam logic [127:0] HOST_SHORT_BYTES = 128'h7777772e6262632e636f2e756b;
  localparam int           HOST_LONG_LEN    = 16;
  localparam int           HOST_SHORT_LEN   = 13;

  typedef enum int {PLANT_NONE, PLANT_LONG, PLANT_SHORT, PLANT_BOTH} host_plant_e;

  class frame_verdict_scoreboard;
    logic [15:0]  watch_port;
    int unsigned  byte_pos;
    logic [15:0]  frame_type;
    logic [3:0]   ip_words;
    logic [7:0]   ip_proto;
    logic [31:0]  src_ip;
    logic [31:0]  dst_ip;
    logic [15:0]  dst_port;
    logic [3:0]   tcp_words;
    logic         syn_bit;
    logic [127:0] window;
    logic [1:0]   host_found;
    logic [31:0]  syn_count;
    logic [31:0]  arp_count;
    logic [31:0]  hit_count;
    result_t      pending_verdicts[$];
    int unsigned  bytes_seen;
    int unsigned  frames_seen;
    int unsigned  verdicts_checked;
    int unsigned  mismatches;

    function new();
      watch_port = DEFAULT_WATCH_PORT;
      syn_count = '0;
      arp_count = '0;
      hit_count = '0;
      bytes_seen = 0;
      frames_seen = 0;
      verdicts_checked = 0;
      mismatches = 0;
      clear_frame();
    endfunction

    function void clear_frame();
      byte_pos = 0;
      frame_type = '0;
      ip_words = '0;
      ip_proto = '0;
      src_ip = '0;
      dst_ip = '0;
      dst_port = '0;
      tcp_words = '0;
      syn_bit = 1'b0;
      window = '0;
      host_found = '0;
    endfunction

    function void set_watch_port(logic [15:0] port);
      watch_port = port;
    endfunction

    function void predict_byte(logic [7:0] b, logic last);
      int unsigned p, ihl, ts, off, ps, len;
      logic [1:0]  kind, hit;
      logic        syn;
      logic [31:0] sa, da;
      result_t     verdict;
      bytes_seen++;
      p = byte_pos;
      window = {window[119:0], b};
      if (p == 12) frame_type[15:8] = b;
      if (p == 13) frame_type[7:0] = b;
      if (p == 14) ip_words = b[3:0];
      if (p == 23) ip_proto = b;
      if (p >= 26 && p <= 29) src_ip = {src_ip[23:0], b};
      if (p >= 30 && p <= 33) dst_ip = {dst_ip[23:0], b};
      ihl = (ip_words < 5) ? 5 : ip_words;
      ts = 14 + 4 * ihl;
      if (p == ts + 2) dst_port[15:8] = b;
      if (p == ts + 3) dst_port[7:0] = b;
      if (p == ts + 12) tcp_words = b[7:4];
      if (p == ts + 13) syn_bit = b[1];
      off = (tcp_words < 5) ? 5 : tcp_words;
      ps = ts + 4 * off;
      if (frame_type == ETH_TYPE_IPV4 && ip_proto == IP_PROTO_TCP) begin
        if (p + 1 >= ps + HOST_LONG_LEN && window == HOST_LONG_BYTES) host_found[0] = 1'b1;
        if (p + 1 >= ps + HOST_SHORT_LEN && window[103:0] == HOST_SHORT_BYTES[103:0])
          host_found[1] = 1'b1;
      end
      if (!last) begin
        if (p < POS_LIMIT) byte_pos = p + 1;
        return;
      end
      len = p + 1;
      kind = KIND_OTHER;
      hit = HIT_NONE;
      syn = 1'b0;
      sa = '0;
      da = '0;
      if (frame_type == ETH_TYPE_ARP && len >= 14) begin
        kind = KIND_ARP;
      end else if (frame_type == ETH_TYPE_IPV4 && len >= 34) begin
        if (ip_proto != IP_PROTO_TCP) kind = KIND_IPV4_OTH;
        else if (len >= ts + 20) kind = KIND_TCP;
      end
      if (kind == KIND_TCP || kind == KIND_IPV4_OTH) begin
        sa = src_ip;
        da = dst_ip;
      end
      if (kind == KIND_TCP) begin
        syn = syn_bit;
        if (dst_port == watch_port) begin
          if (host_found[0]) hit = HIT_A;
          else if (host_found[1]) hit = HIT_B;
        end
        if (syn && syn_count != '1) syn_count++;
        if (hit != HIT_NONE && hit_count != '1) hit_count++;
      end
      if (kind == KIND_ARP && arp_count != '1) arp_count++;
      verdict.packet_kind = kind;
      verdict.syn_seen = syn;
      verdict.blacklist_hit = hit;
      verdict.source_address = sa;
      verdict.dest_address = da;
      verdict.syn_total = syn_count;
      verdict.arp_total = arp_count;
      verdict.blacklist_total = hit_count;
      pending_verdicts.push_back(verdict);
      frames_seen++;
      clear_frame();
    endfunction

    task report(string what);
      mismatches++;
      if (mismatches <= MAX_PRINTED) $display("tb_top: mismatch: %s", what);
    endtask

    task check_field(string name, logic [31:0] got, logic [31:0] want);
      if (got !== want)
        report($sformatf("verdict %0d field %s got 0x%0h, predicted 0x%0h",
                         verdicts_checked, name, got, want));
    endtask

    task check_verdict(result_t got);
      result_t want;
      if (pending_verdicts.size() == 0) begin
        report("result transaction with no frame end waiting for it");
        return;
      end
      want = pending_verdicts.pop_front();
      verdicts_checked++;
      check_field("packet_kind", 32'(got.packet_kind), 32'(want.packet_kind));
      check_field("syn_seen", 32'(got.syn_seen), 32'(want.syn_seen));
      check_field("blacklist_hit", 32'(got.blacklist_hit), 32'(want.blacklist_hit));
      check_field("source_address", got.source_address, want.source_address);
      check_field("dest_address", got.dest_address, want.dest_address);
      check_field("syn_total", got.syn_total, want.syn_total);
      check_field("arp_total", got.arp_total, want.arp_total);
      check_field("blacklist_total", got.blacklist_total, want.blacklist_total);
    endtask
  endclass

endpackage

// ===== dv/tb_top.sv =====
// Top-level testbench of the frame inspector: drives frames byte by byte,
// writes the watched port over APB and checks every result transaction.
// Depends on phui_pkg, phui_if, frame_check_pkg and the design top level.
module tb_top;
  import phui_pkg::*;
  import frame_check_pkg::*;

  localparam int WATCHDOG_LIMIT  = 3000;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int DRAIN_CYCLES    = 6;
  localparam logic [CFG_ADDR_W-1:0] REG_WATCH_PORT = '0;

  logic                  clk;
  logic                  rst_n;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [CFG_DATA_W-1:0] pwdata;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;

  phui_in_if  in_bus();
  phui_out_if out_bus();

  frame_verdict_scoreboard verdicts;
  result_t     seen_verdict;
  logic [7:0]  frame_buf[$];
  int          send_idle_pct = 0;
  int          recv_idle_pct = 0;
  int          hold_requests = 0;
  int          holds_served = 0;
  int          hold_left = 0;
  int          idle_cycles = 0;

  packet_header_and_url_inspector_unit uut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_chan (in_bus),
    .out_chan(out_bus),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst_n && out_bus.valid && out_bus.ready) begin
      seen_verdict = {out_bus.packet_kind, out_bus.syn_seen, out_bus.blacklist_hit,
                      out_bus.source_address, out_bus.dest_address, out_bus.syn_total,
                      out_bus.arp_total, out_bus.blacklist_total};
      verdicts.check_verdict(seen_verdict);
    end
    if (holds_served != hold_requests) begin
      holds_served = hold_requests;
      hold_left = HOLD_OFF_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_bus.ready <= 1'b0;
    end else begin
      out_bus.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("tb_top: no transaction for %0d cycles", idle_cycles);
      $display("tb_top: FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      in_bus.valid <= 1'b0;
      @(posedge clk);
    end
    in_bus.valid <= 1'b1;
    in_bus.frame_byte <= b;
    in_bus.end_of_frame <= last;
    @(posedge clk);
    while (!in_bus.ready) @(posedge clk);
    verdicts.predict_byte(b, last);
  endtask

  task automatic send_frame();
    foreach (frame_buf[i]) send_byte(frame_buf[i], i == frame_buf.size() - 1);
  endtask

  task automatic wait_drain();
    in_bus.valid <= 1'b0;
    while (verdicts.pending_verdicts.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [15:0] port);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= REG_WATCH_PORT;
    pwdata <= {16'h0, port};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    verdicts.set_watch_port(port);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
  endtask

  task automatic cfg_check_port();
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= REG_WATCH_PORT;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (prdata !== {16'h0, verdicts.watch_port})
      verdicts.report($sformatf("watch_port read 0x%0h, written 0x%0h", prdata,
                                verdicts.watch_port));
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic fill_random(input int len);
    frame_buf.delete();
    repeat (len) frame_buf.push_back(8'($urandom));
  endtask

  task automatic cut_frame(input int len);
    while (frame_buf.size() > len) void'(frame_buf.pop_back());
  endtask

  task automatic set_type(input logic [15:0] etype);
    frame_buf[12] = etype[15:8];
    frame_buf[13] = etype[7:0];
  endtask

  task automatic place_host(input int at, input logic [127:0] host, input int hlen);
    for (int k = 0; k < hlen; k++)
      if (at + k >= 0 && at + k < frame_buf.size()) frame_buf[at + k] = host[8*(hlen-1-k) +: 8];
  endtask

  task automatic build_frame(input logic [15:0] etype, input logic [3:0] ihl,
                             input logic [7:0] proto, input logic [15:0] port,
                             input logic [3:0] doff, input logic syn, input int pay_len,
                             input host_plant_e plant, input int plant_at);
    int ts, ps;
    ts = 14 + 4 * ((ihl < 5) ? 5 : ihl);
    ps = ts + 4 * ((doff < 5) ? 5 : doff);
    fill_random(ps + pay_len);
    set_type(etype);
    frame_buf[14] = {4'($urandom), ihl};
    frame_buf[23] = proto;
    frame_buf[ts + 2] = port[15:8];
    frame_buf[ts + 3] = port[7:0];
    frame_buf[ts + 12] = {doff, 4'($urandom)};
    frame_buf[ts + 13] = {6'($urandom), syn, 1'($urandom)};
    if (plant == PLANT_LONG || plant == PLANT_BOTH)
      place_host(ps + plant_at, HOST_LONG_BYTES, HOST_LONG_LEN);
    if (plant == PLANT_SHORT)
      place_host(ps + plant_at, HOST_SHORT_BYTES, HOST_SHORT_LEN);
    if (plant == PLANT_BOTH)
      place_host(ps + plant_at + HOST_LONG_LEN, HOST_SHORT_BYTES, HOST_SHORT_LEN);
  endtask

  task automatic run_directed();
    fill_random(1);
    send_frame();
    fill_random(13);
    frame_buf[12] = ETH_TYPE_ARP[15:8];
    send_frame();
    fill_random(14);
    set_type(ETH_TYPE_ARP);
    send_frame();
    fill_random(60);
    set_type(ETH_TYPE_ARP);
    send_frame();
    build_frame(ETH_TYPE_IPV4, 4'd5, IP_PROTO_UDP, 16'd80, 4'd5, 1'b0, 20, PLANT_NONE, 0);
    cut_frame(33);
    send_frame();
    build_frame(ETH_TYPE_IPV4, 4'd5, IP_PROTO_UDP, 16'd80, 4'd5, 1'b0, 20, PLANT_NONE, 0);
    cut_frame(34);
    send_frame();
    build_frame(ETH_TYPE_IPV4, 4'd5, IP_PROTO_TCP, 16'd80, 4'd5, 1'b1, 0, PLANT_NONE, 0);
    cut_frame(53);
    send_frame();
    build_frame(ETH_TYPE_IPV4, 4'd5, IP_PROTO_TCP, 16'd80, 4'd5, 1'b1, 0, PLANT_NONE, 0);
    send_frame();
    build_frame(ETH_TYPE_IPV4, 4'd0, IP_PROTO_TCP, 16'd80, 4'd0, 1'b0, 16, PLANT_LONG, 0);
    send_frame();
    build_frame(ETH_TYPE_IPV4, 4'd15, IP_PROTO_TCP, 16'd80, 4'd15, 1'b1, 20, PLANT_SHORT, 2);
    send_frame();
    build_frame(ETH_TYPE_IPV4, 4'd5, IP_PROTO_TCP, 16'd80, 4'd5, 1'b0, 32, PLANT_BOTH, 0);
    send_frame();
    build_frame(ETH_TYPE_IPV4, 4'd5, IP_PROTO_TCP, 16'd80, 4'd5, 1'b0, 15, PLANT_LONG, -1);
    send_frame();
    build_frame(ETH_TYPE_IPV4, 4'd5, IP_PROTO_TCP, 16'd80, 4'd5, 1'b0, 10, PLANT_LONG, 4);
    send_frame();
    build_frame(ETH_TYPE_IPV4, 4'd5, IP_PROTO_TCP, 16'd80, 4'd5, 1'b0, 13, PLANT_SHORT, 0);
    send_frame();
    build_frame(ETH_TYPE_IPV4, 4'd5, IP_PROTO_TCP, 16'd81, 4'd5, 1'b1, 16, PLANT_LONG, 0);
    send_frame();
    frame_buf.delete();
    repeat (60) frame_buf.push_back(8'h00);
    send_frame();
    frame_buf.delete();
    repeat (60) frame_buf.push_back(8'hFF);
    send_frame();
    build_frame(ETH_TYPE_IPV4, 4'd5, 8'hFF, 16'd0, 4'd5, 1'b0, 10, PLANT_NONE, 0);
    for (int k = 26; k < 30; k++) frame_buf[k] = 8'h00;
    for (int k = 30; k < 34; k++) frame_buf[k] = 8'hFF;
    send_frame();
    build_frame(ETH_TYPE_IPV4, 4'd5, IP_PROTO_TCP, 16'hFFFF, 4'd5, 1'b0, 8, PLANT_NONE, 0);
    for (int k = 26; k < 30; k++) frame_buf[k] = 8'hFF;
    for (int k = 30; k < 34; k++) frame_buf[k] = 8'h00;
    send_frame();
  endtask

  task automatic random_frame();
    int          sel, pay, at;
    logic [15:0] port;
    logic [3:0]  ihl, doff;
    host_plant_e plant;
    sel = $urandom_range(99);
    port = ($urandom_range(9) < 7) ? verdicts.watch_port : 16'($urandom);
    ihl = ($urandom_range(3) == 0) ? 4'($urandom) : 4'd5;
    doff = ($urandom_range(3) == 0) ? 4'($urandom) : 4'd5;
    pay = $urandom_range(24);
    plant = $urandom_range(1) ? host_plant_e'($urandom_range(3)) : PLANT_NONE;
    at = int'($urandom_range(pay + 6)) - 4;
    if (sel < 60) begin
      build_frame(ETH_TYPE_IPV4, ihl, IP_PROTO_TCP, port, doff, 1'($urandom), pay, plant, at);
    end else if (sel < 70) begin
      build_frame(ETH_TYPE_IPV4, ihl, 8'($urandom), port, doff, 1'($urandom), pay, plant, at);
      cut_frame($urandom_range(30, frame_buf.size()));
    end else if (sel < 80) begin
      fill_random(64);
      set_type(ETH_TYPE_ARP);
      cut_frame($urandom_range(10, 64));
    end else if (sel < 90) begin
      build_frame(ETH_TYPE_IPV4, ihl, IP_PROTO_TCP, port, doff, 1'($urandom), pay, plant, at);
      cut_frame($urandom_range(1, frame_buf.size()));
    end else begin
      fill_random($urandom_range(1, 70));
    end
  endtask

  task automatic run_random(input int unsigned min_bytes, input int unsigned min_frames);
    int unsigned bytes0, frames0;
    bytes0 = verdicts.bytes_seen;
    frames0 = verdicts.frames_seen;
    while (verdicts.bytes_seen - bytes0 < min_bytes ||
           verdicts.frames_seen - frames0 < min_frames) begin
      random_frame();
      send_frame();
    end
  endtask

  initial begin
    verdicts = new();
    rst_n <= 1'b0;
    in_bus.valid <= 1'b0;
    in_bus.frame_byte <= '0;
    in_bus.end_of_frame <= 1'b0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    cfg_check_port();

    send_idle_pct = 6;
    recv_idle_pct = 57;
    run_directed();
    wait_drain();
    cfg_write(16'd0);
    cfg_check_port();
    run_random(80, 2);
    // The receiver stops while short frames keep arriving, so the block backs up.
    hold_requests++;
    repeat (40) begin
      fill_random(1);
      send_frame();
    end
    wait_drain();

    send_idle_pct = 57;
    recv_idle_pct = 6;
    cfg_write(16'hFFFF);
    cfg_check_port();
    run_random(80, 2);
    wait_drain();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    cfg_write(16'($urandom));
    cfg_check_port();
    run_random(80, 2);
    wait_drain();

    $display("tb_top: %0d bytes in %0d frames sent, %0d results checked, %0d mismatches",
             verdicts.bytes_seen, verdicts.frames_seen, verdicts.verdicts_checked,
             verdicts.mismatches);
    $display("tb_top: covered ARP, IPv4 and TCP frames, truncation, host matches, %s",
             "a long receiver stall and watched ports 80, 0, 65535 and random");
    if (verdicts.mismatches == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule
